@@ rtl/core/cmdtok_pkg.sv @@
// constants and character helpers shared by the command line tokenizer
package cmdtok_pkg;

    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 3;
    localparam int KIND_W  = 2;
    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;

    localparam logic [BYTE_W-1:0] CH_BS      = 8'd8;
    localparam logic [BYTE_W-1:0] CH_LF      = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [BYTE_W-1:0] CH_AMP     = 8'd38;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'd48;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'd57;
    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'd65;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'd90;
    localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'd97;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'd122;
    localparam logic [BYTE_W-1:0] CH_DEL     = 8'd127;

    localparam logic [KIND_W-1:0] KIND_ALPHA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NUM   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_AMP   = 2'd2;

    function automatic logic f_is_field(input logic [BYTE_W-1:0] c);
        return (c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z],
                          [CH_ZERO:CH_NINE], CH_AMP});
    endfunction

    function automatic logic [KIND_W-1:0] f_kind(input logic [BYTE_W-1:0] c);
        logic [KIND_W-1:0] k;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            k = KIND_NUM;
        end else if (c == CH_AMP) begin
            k = KIND_AMP;
        end else begin
            k = KIND_ALPHA;
        end
        return k;
    endfunction

endpackage

@@ rtl/core/cmdtok_if.sv @@
// valid/ready channels for received bytes and for field results
interface cmdtok_rx_if;
    logic                               valid;
    logic                               ready;
    logic [cmdtok_pkg::BYTE_W-1:0]      rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cmdtok_fld_if;
    logic                               valid;
    logic                               ready;
    logic [cmdtok_pkg::IDX_W-1:0]       field_index;
    logic [cmdtok_pkg::KIND_W-1:0]      field_kind;
    logic [cmdtok_pkg::POS_W-1:0]       field_start;
    logic [cmdtok_pkg::POS_W-1:0]       field_length;
    logic [cmdtok_pkg::VALUE_W-1:0]     numeric_value;
    logic [cmdtok_pkg::IDX_W-1:0]       field_total;
    logic                               line_was_full;
    logic                               fields_dropped;
    logic                               last_of_line;

    modport source (output valid, output field_index, output field_kind,
                    output field_start, output field_length, output numeric_value,
                    output field_total, output line_was_full, output fields_dropped,
                    output last_of_line, input ready);
    modport sink   (input valid, input field_index, input field_kind,
                    input field_start, input field_length, input numeric_value,
                    input field_total, input line_was_full, input fields_dropped,
                    input last_of_line, output ready);
endinterface

@@ rtl/core/cmdtok_ram.sv @@
// generic single write port, single read port ram with registered read
module cmdtok_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/command_line_tokenizer.sv @@
// command line tokenizer: line buffer in ram, field scan and field result output
// a byte is taken while idle; ready stays low while a line is scanned and sent
// line end: the scan reads the stored characters from ram in turn (one ram read per stored character),
// then the field results are sent one by one through the output register as it frees
// the last result waits in the output register while the next bytes are taken
// synchronous active-low reset clears the character count and control; ram is not cleared
module command_line_tokenizer #(
    parameter int LINE_CHARS  = 80,
    parameter int FIELD_LIMIT = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cmdtok_rx_if.sink     i_rx,
    cmdtok_fld_if.source  o_fld
);

    localparam int CW = $clog2(LINE_CHARS + 1);
    localparam int AW = $clog2(LINE_CHARS);
    localparam int NW = $clog2(FIELD_LIMIT + 1);
    localparam int RI = (FIELD_LIMIT > 1) ? $clog2(FIELD_LIMIT) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH, ST_EMIT} t_state;

    typedef struct packed {
        logic [cmdtok_pkg::KIND_W-1:0]  kind;
        logic [CW-1:0]                  start;
        logic [CW-1:0]                  len;
        logic [cmdtok_pkg::VALUE_W-1:0] value;
    } t_rec;

    t_state                          r_state;
    logic [CW-1:0]                   r_count;
    logic                            r_full;
    logic [CW-1:0]                   r_rd_ptr;
    logic                            r_rd_act;
    logic [CW-1:0]                   r_pos;
    logic                            r_in_field;
    t_rec                            r_cur;
    logic [NW-1:0]                   r_nf;
    logic                            r_dropped;
    logic [NW-1:0]                   r_emit_idx;
    t_rec                            r_rec [FIELD_LIMIT];

    logic                            r_ov;
    logic [cmdtok_pkg::IDX_W-1:0]    r_o_index;
    logic [cmdtok_pkg::KIND_W-1:0]   r_o_kind;
    logic [cmdtok_pkg::POS_W-1:0]    r_o_start;
    logic [cmdtok_pkg::POS_W-1:0]    r_o_len;
    logic [cmdtok_pkg::VALUE_W-1:0]  r_o_value;
    logic [cmdtok_pkg::IDX_W-1:0]    r_o_total;
    logic                            r_o_full;
    logic                            r_o_dropped;
    logic                            r_o_last;

    logic [cmdtok_pkg::BYTE_W-1:0]   rd_data;
    logic [cmdtok_pkg::BYTE_W-1:0]   in_byte;
    logic                            in_take;
    logic                            in_erase;
    logic                            in_eol;
    logic                            in_store;
    logic                            ch_field;
    logic [cmdtok_pkg::VALUE_W-1:0]  n_value;
    logic                            commit;
    logic                            out_free;
    t_rec                            emit_rec;

    assign in_byte  = i_rx.rx_byte;
    assign in_take  = i_rx.valid && i_rx.ready;
    assign in_erase = (in_byte == cmdtok_pkg::CH_BS) || (in_byte == cmdtok_pkg::CH_DEL);
    assign in_eol   = (in_byte == cmdtok_pkg::CH_CR) || (in_byte == cmdtok_pkg::CH_LF);
    assign in_store = !in_erase && !in_eol && (in_byte >= cmdtok_pkg::CH_SPACE);

    assign i_rx.ready = (r_state == ST_IDLE);

    cmdtok_ram #(
        .WIDTH (cmdtok_pkg::BYTE_W),
        .DEPTH (LINE_CHARS)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_take && in_store),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (in_byte),
        .i_rd_addr (r_rd_ptr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // value = value * 10 + c - '0', wrapping
    assign ch_field = cmdtok_pkg::f_is_field(rd_data);
    assign n_value  = {r_cur.value[cmdtok_pkg::VALUE_W-4:0], 3'b000}
                    + {r_cur.value[cmdtok_pkg::VALUE_W-2:0], 1'b0}
                    + cmdtok_pkg::VALUE_W'(rd_data)
                    - cmdtok_pkg::VALUE_W'(cmdtok_pkg::CH_ZERO);

    // a field closes on a delimiter or at the end of the line
    assign commit = r_in_field &&
                    (((r_state == ST_SCAN) && r_rd_act && !ch_field) ||
                     (r_state == ST_FLUSH));

    assign out_free = !r_ov || o_fld.ready;
    assign emit_rec = r_rec[r_emit_idx[RI-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_full     <= 1'b0;
            r_rd_ptr   <= '0;
            r_rd_act   <= 1'b0;
            r_pos      <= '0;
            r_in_field <= 1'b0;
            r_nf       <= '0;
            r_dropped  <= 1'b0;
            r_emit_idx <= '0;
            r_ov       <= 1'b0;
        end else begin
            // in emit a taken word is replaced by the next one
            if (o_fld.valid && o_fld.ready && (r_state != ST_EMIT)) begin
                r_ov <= 1'b0;
            end

            if (commit) begin
                if (r_nf < NW'(FIELD_LIMIT)) begin
                    r_rec[r_nf[RI-1:0]] <= r_cur;
                    r_nf                <= r_nf + 1'b1;
                end else begin
                    r_dropped <= 1'b1;
                end
            end

            case (r_state)
                ST_IDLE: begin
                    r_rd_ptr   <= '0;
                    r_rd_act   <= 1'b0;
                    r_pos      <= '0;
                    r_in_field <= 1'b0;
                    r_nf       <= '0;
                    r_dropped  <= 1'b0;
                    r_emit_idx <= '0;
                    if (in_take) begin
                        if (in_erase) begin
                            if (r_count != '0) begin
                                r_count <= r_count - 1'b1;
                            end
                        end else if (in_eol) begin
                            r_full  <= 1'b0;
                            r_state <= ST_SCAN;
                        end else if (in_store) begin
                            r_count <= r_count + 1'b1;
                            if (r_count + CW'(1) == CW'(LINE_CHARS)) begin
                                r_full  <= 1'b1;
                                r_state <= ST_SCAN;
                            end
                        end
                    end
                end

                ST_SCAN: begin
                    if (r_rd_ptr != r_count) begin
                        r_rd_ptr <= r_rd_ptr + 1'b1;
                        r_rd_act <= 1'b1;
                    end else begin
                        r_rd_act <= 1'b0;
                        if (!r_rd_act) begin
                            r_state <= ST_FLUSH;
                        end
                    end
                    if (r_rd_act) begin
                        r_pos <= r_pos + 1'b1;
                        if (ch_field) begin
                            r_in_field <= 1'b1;
                            if (!r_in_field) begin
                                r_cur.kind  <= cmdtok_pkg::f_kind(rd_data);
                                r_cur.start <= r_pos;
                                r_cur.len   <= CW'(1);
                                r_cur.value <= cmdtok_pkg::VALUE_W'(rd_data)
                                             - cmdtok_pkg::VALUE_W'(cmdtok_pkg::CH_ZERO);
                            end else begin
                                r_cur.len   <= r_cur.len + 1'b1;
                                r_cur.value <= n_value;
                            end
                        end else begin
                            r_in_field <= 1'b0;
                        end
                    end
                end

                ST_FLUSH: begin
                    r_in_field <= 1'b0;
                    r_count    <= '0;
                    r_state    <= ST_EMIT;
                end

                ST_EMIT: begin
                    if (out_free) begin
                        r_ov     <= 1'b1;
                        r_o_full <= r_full;
                        if (r_nf == '0) begin
                            // line without fields gives one empty word
                            r_o_index   <= '0;
                            r_o_kind    <= '0;
                            r_o_start   <= '0;
                            r_o_len     <= '0;
                            r_o_value   <= '0;
                            r_o_total   <= '0;
                            r_o_dropped <= 1'b0;
                            r_o_last    <= 1'b1;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_o_index   <= cmdtok_pkg::IDX_W'(r_emit_idx);
                            r_o_kind    <= emit_rec.kind;
                            r_o_start   <= cmdtok_pkg::POS_W'(emit_rec.start);
                            r_o_len     <= cmdtok_pkg::POS_W'(emit_rec.len);
                            r_o_value   <= (emit_rec.kind == cmdtok_pkg::KIND_NUM) ?
                                           emit_rec.value : '0;
                            r_o_total   <= cmdtok_pkg::IDX_W'(r_nf);
                            r_o_dropped <= r_dropped;
                            r_o_last    <= (r_emit_idx + 1'b1 == r_nf);
                            r_emit_idx  <= r_emit_idx + 1'b1;
                            if (r_emit_idx + 1'b1 == r_nf) begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_fld.valid          = r_ov;
    assign o_fld.field_index    = r_o_index;
    assign o_fld.field_kind     = r_o_kind;
    assign o_fld.field_start    = r_o_start;
    assign o_fld.field_length   = r_o_len;
    assign o_fld.numeric_value  = r_o_value;
    assign o_fld.field_total    = r_o_total;
    assign o_fld.line_was_full  = r_o_full;
    assign o_fld.fields_dropped = r_o_dropped;
    assign o_fld.last_of_line   = r_o_last;

endmodule
